// ===== rtl/fsbs_pkg.sv =====
// Package for the fan speed button synchroniser.
// Holds the beat structs, register indexes and reset values; depends on nothing.
`default_nettype none

package fsbs_pkg;

    // One input beat: a timer tick with a line sample, or a remote setpoint write.
    typedef struct packed {
        logic       func;
        logic [2:0] indicator_lines;
        logic [1:0] requested_speed;
    } in_t;

    // One result beat: the state as it stands after the item was handled.
    typedef struct packed {
        logic       button_level;
        logic [1:0] confirmed_out;
        logic [1:0] setpoint_out;
        logic       status_changed;
        logic [1:0] mode_out;
    } out_t;

    // Function codes of an input beat.
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_REMOTE = 1'b1;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_HIGH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_LOW   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PRESSES = 2'd2;

    // Register reset values.
    localparam logic [7:0] PULSE_HIGH_RESET  = 8'd2;
    localparam logic [7:0] PULSE_LOW_RESET   = 8'd2;
    localparam logic [3:0] MAX_PRESSES_RESET = 4'd8;

    // Saturation point of the press counter.
    localparam logic [3:0] PRESS_COUNT_MAX = 4'd15;

endpackage

`default_nettype wire

// ===== rtl/fan_speed_button_sync_top.sv =====
// Top level of the fan speed button synchroniser: input handshake, result register
// and skid stage. Depends on fsbs_pkg and fsbs_core.
`default_nettype none

// Each accepted beat (a timer tick or a remote setpoint write) updates the controller
// state in the cycle it is taken and yields exactly one result beat, which appears on
// the result port via a register. A new beat can be taken in every cycle: the whole
// per-item update is a single pass of logic into the state registers, and a result
// register backed by a one-entry skid stage lets the input keep flowing while a
// result waits. Input stall rises only while the skid stage is occupied. Writes on the
// configuration port take effect at once and should be made while no beat is in flight.
module fan_speed_button_sync_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [fsbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fsbs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire fsbs_pkg::in_t                    in_item,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output fsbs_pkg::out_t                        out_item
);
    import fsbs_pkg::*;

    logic accept;
    logic out_free;
    out_t result;
    out_t out_reg;
    out_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    fsbs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (in_item),
        .result    (result)
    );

    // Result beat control: the skid entry drains first, keeping beats in order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg  <= accept;
        end
        else if (accept)
            skid_valid_reg <= 1'b1;
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= result;
        end
        else if (accept)
            skid_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // The skid stage is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a beat while the result register is empty");

    // A beat taken while the result waits must land in the skid stage.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && accept) |=> skid_valid_reg)
        else $error("beat accepted behind a stalled result was lost");

    // A drained skid entry moves into the result register.
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry did not move into the result register");

    // No beat is accepted while the skid stage is full, so both buffered beats stay put.
    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_stall) |=> (skid_valid_reg && out_valid_reg))
        else $error("buffered beats changed while the output was stalled");

endmodule

`default_nettype wire

// ===== rtl/fsbs_core.sv =====
// State and update logic of the fan speed button synchroniser.
// Depends on fsbs_pkg for the beat structs, register indexes and reset values.
`default_nettype none

module fsbs_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [fsbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fsbs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             accept,
    input  wire fsbs_pkg::in_t                    item,
    output fsbs_pkg::out_t                        result
);
    import fsbs_pkg::*;

    typedef enum logic [1:0] {
        MODE_WATCH = 2'd0,
        MODE_ADOPT = 2'd1,
        MODE_PRESS = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_CHECK = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2
    } phase_t;

    logic [7:0] pulse_high_reg;
    logic [7:0] pulse_low_reg;
    logic [3:0] max_presses_reg;

    mode_t      mode_reg,        mode_next;
    phase_t     phase_reg,       phase_next;
    logic [1:0] confirmed_reg,   confirmed_next;
    logic [1:0] setpoint_reg,    setpoint_next;
    logic [1:0] sampled_reg,     sampled_next;
    logic [1:0] target_reg,      target_next;
    logic [7:0] phase_count_reg, phase_count_next;
    logic [3:0] press_count_reg, press_count_next;
    logic       changed;
    logic [1:0] decoded;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_high_reg  <= PULSE_HIGH_RESET;
            pulse_low_reg   <= PULSE_LOW_RESET;
            max_presses_reg <= MAX_PRESSES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PULSE_HIGH:  pulse_high_reg  <= cfg_data;
                REG_PULSE_LOW:   pulse_low_reg   <= cfg_data;
                REG_MAX_PRESSES: max_presses_reg <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    // Priority decode of the active-low indicator lines, highest line first.
    always_comb
    begin
        if (!item.indicator_lines[2])
            decoded = 2'd3;
        else if (!item.indicator_lines[1])
            decoded = 2'd2;
        else if (!item.indicator_lines[0])
            decoded = 2'd1;
        else
            decoded = 2'd0;
    end

    // Next state for one item.
    always_comb
    begin
        mode_next        = mode_reg;
        phase_next       = phase_reg;
        confirmed_next   = confirmed_reg;
        setpoint_next    = setpoint_reg;
        sampled_next     = sampled_reg;
        target_next      = target_reg;
        phase_count_next = phase_count_reg;
        press_count_next = press_count_reg;
        changed          = 1'b0;

        if (item.func == FUNC_REMOTE)
        begin
            setpoint_next = item.requested_speed;
        end
        else
        begin
            case (mode_reg)
                MODE_WATCH:
                begin
                    if (decoded != confirmed_reg)
                    begin
                        sampled_next = decoded;
                        mode_next    = MODE_ADOPT;
                    end
                    else if (decoded != setpoint_reg)
                    begin
                        sampled_next     = decoded;
                        target_next      = setpoint_reg;
                        press_count_next = 4'd0;
                        phase_next       = PH_CHECK;
                        phase_count_next = 8'd0;
                        mode_next        = MODE_PRESS;
                    end
                end
                MODE_ADOPT:
                begin
                    confirmed_next = sampled_reg;
                    setpoint_next  = sampled_reg;
                    changed        = 1'b1;
                    mode_next      = MODE_WATCH;
                end
                MODE_PRESS:
                begin
                    case (phase_reg)
                        PH_HIGH:
                        begin
                            if (phase_count_reg >= pulse_high_reg)
                            begin
                                phase_next       = PH_LOW;
                                phase_count_next = 8'd1;
                            end
                            else
                                phase_count_next = phase_count_reg + 8'd1;
                        end
                        PH_LOW:
                        begin
                            if (phase_count_reg >= pulse_low_reg)
                            begin
                                phase_next       = PH_CHECK;
                                phase_count_next = 8'd0;
                                if (press_count_reg < PRESS_COUNT_MAX)
                                    press_count_next = press_count_reg + 4'd1;
                            end
                            else
                                phase_count_next = phase_count_reg + 8'd1;
                        end
                        default:
                        begin
                            // Check phase: stop on a match or once the press limit is hit.
                            if (decoded == target_reg || press_count_reg >= max_presses_reg)
                            begin
                                setpoint_next    = decoded;
                                mode_next        = MODE_WATCH;
                                phase_next       = PH_CHECK;
                                phase_count_next = 8'd0;
                            end
                            else
                            begin
                                phase_next       = PH_HIGH;
                                phase_count_next = 8'd1;
                            end
                        end
                    endcase
                end
                default:
                    mode_next = MODE_WATCH;
            endcase
        end
    end

    // State registers advance only on an accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_WATCH;
            phase_reg       <= PH_CHECK;
            confirmed_reg   <= 2'd0;
            setpoint_reg    <= 2'd0;
            sampled_reg     <= 2'd0;
            target_reg      <= 2'd0;
            phase_count_reg <= 8'd0;
            press_count_reg <= 4'd0;
        end
        else if (accept)
        begin
            mode_reg        <= mode_next;
            phase_reg       <= phase_next;
            confirmed_reg   <= confirmed_next;
            setpoint_reg    <= setpoint_next;
            sampled_reg     <= sampled_next;
            target_reg      <= target_next;
            phase_count_reg <= phase_count_next;
            press_count_reg <= press_count_next;
        end
    end

    // Result shows the state after the item.
    always_comb
    begin
        result.button_level   = (mode_next == MODE_PRESS) && (phase_next == PH_HIGH);
        result.confirmed_out  = confirmed_next;
        result.setpoint_out   = setpoint_next;
        result.status_changed = changed;
        result.mode_out       = mode_next;
    end

endmodule

`default_nettype wire
